### hw/rtl/jdc_pkg.sv
`default_nettype none

package jdc_pkg;

  // Field widths.
  localparam int unsigned DAY_W   = 23;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned YEAR_W  = 16;

  // Gregorian switch-over and century correction.
  // alpha = floor((4*(J-1867216) - 1) / 146097), numerator below 2**25.
  localparam logic [22:0] GREG_START    = 23'd2299161;
  localparam logic [24:0] ALPHA_NUM_OFF = 25'd7468865;  // 4*1867216 + 1
  localparam logic [17:0] ALPHA_DIV     = 18'd146097;
  localparam logic [7:0]  ALPHA_RECIP   = 8'd229;       // floor(2**25 / 146097)
  localparam int unsigned ALPHA_SHIFT   = 25;

  localparam logic [23:0] DAY_OFFSET = 24'd1524;

  // c = floor((100*b - 12210) / 36525), numerator below 2**30.
  localparam logic [29:0] YEAR_NUM_OFF = 30'd12210;
  localparam logic [15:0] YEAR_DIV     = 16'd36525;
  localparam logic [21:0] YEAR_MUL     = 22'd2939700;     // 100 * floor(2**30 / 36525)
  localparam logic [28:0] YEAR_BIAS    = 29'd358937370;   // 12210 * floor(2**30 / 36525)
  localparam int unsigned YEAR_SHIFT   = 30;

  // e = floor(10000*rem / 306001).
  localparam logic [18:0] MONTH_NUM   = 19'd306001;
  localparam logic [13:0] MONTH_DEN   = 14'd10000;
  localparam logic [11:0] MONTH_RECIP = 12'd2141;        // floor(10000 * 2**16 / 306001)
  localparam int unsigned MONTH_SHIFT = 16;

  localparam logic signed [16:0] YEAR_BASE = 17'sd4715;

  // floor(30.6001 * e): days counted before month index e.
  function automatic logic [8:0] days_before(input logic [3:0] e);
    logic [8:0] t;
    unique case (e)
      4'd0:    t = 9'd0;
      4'd1:    t = 9'd30;
      4'd2:    t = 9'd61;
      4'd3:    t = 9'd91;
      4'd4:    t = 9'd122;
      4'd5:    t = 9'd153;
      4'd6:    t = 9'd183;
      4'd7:    t = 9'd214;
      4'd8:    t = 9'd244;
      4'd9:    t = 9'd275;
      4'd10:   t = 9'd306;
      4'd11:   t = 9'd336;
      4'd12:   t = 9'd367;
      4'd13:   t = 9'd397;
      4'd14:   t = 9'd428;
      default: t = 9'd459;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/jdc_ifs.sv
`default_nettype none

interface jdc_in_if import jdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   day_number;

  modport source (output valid, output day_number, input ready);
  modport sink   (input valid, input day_number, output ready);
endinterface

interface jdc_out_if import jdc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MONTH_W-1:0]       month;
  logic [DOM_W-1:0]         day_of_month;
  logic signed [YEAR_W-1:0] year;

  modport source (output valid, output month, output day_of_month, output year, input ready);
  modport sink   (input valid, input month, input day_of_month, input year, output ready);
endinterface

`default_nettype wire

### hw/rtl/julian_day_to_calendar_date_core.sv
// Julian day number to calendar date converter.
//
// One item on in_chan carries a Julian day number; one item on out_chan
// carries the month, day of month and year it falls on. Days from
// 15 October 1582 onward are read in the Gregorian calendar, earlier days
// in the Julian calendar, and there is no year zero (1 BC is -1).
// Both channels use a valid/ready handshake; an item moves on a rising
// edge of clk at which valid and ready are both high.
// The datapath is a nine-stage pipeline: a result is shown on out_chan
// once its item reaches the output register, and one item is accepted in
// every cycle while out_chan keeps taking results. The depth is set by the
// three constant divisions, each done as a reciprocal multiply followed by
// a remainder check that adds one where the estimate falls short.
// When the receiver stalls, the results hold in place and bubbles in
// earlier stages still fill, so in_chan stays ready until every stage is
// full. Synchronous reset (rst_n low) empties the pipeline; no result is
// shown until a new item has passed all nine stages.

`default_nettype none

module julian_day_to_calendar_date_core import jdc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jdc_in_if.sink     in_chan,
  jdc_out_if.source  out_chan
);

  // Stage valid bits and per-stage ready. A stage may load when it is empty
  // or when the stage after it is moving on.
  logic [9:1]  v_r;
  logic [9:1]  v_in;
  logic [10:1] rdy;

  assign rdy[10]   = out_chan.ready;
  assign rdy[9:1]  = ~v_r | rdy[10:2];
  assign v_in      = {v_r[8:1], in_chan.valid};

  assign in_chan.ready  = rdy[1];
  assign out_chan.valid = v_r[9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= 9; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 1: Gregorian test and estimate of the century correction.
  logic [22:0] s1_j_r,    s1_j_nxt;
  logic        s1_greg_r, s1_greg_nxt;
  logic [24:0] s1_xa_r,   s1_xa_nxt;
  logic [7:0]  s1_qa_r,   s1_qa_nxt;
  logic [32:0] s1_pa;

  always_comb begin
    s1_j_nxt    = in_chan.day_number;
    s1_greg_nxt = (in_chan.day_number >= GREG_START);
    // For Julian-calendar days this can wrap; the result is not used then.
    s1_xa_nxt   = {in_chan.day_number, 2'b00} - ALPHA_NUM_OFF;
    s1_pa       = 33'(s1_xa_nxt) * 33'(ALPHA_RECIP);
    s1_qa_nxt   = s1_pa[ALPHA_SHIFT +: 8];
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_j_r    <= s1_j_nxt;
      s1_greg_r <= s1_greg_nxt;
      s1_xa_r   <= s1_xa_nxt;
      s1_qa_r   <= s1_qa_nxt;
    end
  end

  // Stage 2: the estimate is at most one short; the remainder settles it.
  logic [22:0] s2_j_r;
  logic        s2_greg_r;
  logic [7:0]  s2_alpha_r, s2_alpha_nxt;
  logic [24:0] s2_ra;

  always_comb begin
    s2_ra        = s1_xa_r - 25'(26'(s1_qa_r) * 26'(ALPHA_DIV));
    s2_alpha_nxt = s1_qa_r + 8'(s2_ra >= 25'(ALPHA_DIV));
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_j_r     <= s1_j_r;
      s2_greg_r  <= s1_greg_r;
      s2_alpha_r <= s2_alpha_nxt;
    end
  end

  // Stage 3: b = a + 1524, with the Gregorian correction folded into a.
  logic [23:0] s3_b_r, s3_b_nxt;

  always_comb begin
    if (s2_greg_r) begin
      s3_b_nxt = 24'(s2_j_r) + 24'(s2_alpha_r) - 24'(s2_alpha_r[7:2]) + DAY_OFFSET + 24'd1;
    end else begin
      s3_b_nxt = 24'(s2_j_r) + DAY_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_b_r <= s3_b_nxt;
    end
  end

  // Stage 4: year count estimate; the offset is folded into the product.
  logic [23:0] s4_b_r;
  logic [29:0] s4_xc_r, s4_xc_nxt;
  logic [14:0] s4_qc_r, s4_qc_nxt;
  logic [45:0] s4_pc;

  always_comb begin
    s4_xc_nxt = 30'(s3_b_r) * 30'd100 - YEAR_NUM_OFF;
    s4_pc     = 46'(s3_b_r) * 46'(YEAR_MUL) - 46'(YEAR_BIAS);
    s4_qc_nxt = s4_pc[YEAR_SHIFT +: 15];
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_b_r  <= s3_b_r;
      s4_xc_r <= s4_xc_nxt;
      s4_qc_r <= s4_qc_nxt;
    end
  end

  // Stage 5: year count correction.
  logic [23:0] s5_b_r;
  logic [14:0] s5_c_r, s5_c_nxt;
  logic [29:0] s5_rc;

  always_comb begin
    s5_rc    = s4_xc_r - 30'(31'(s4_qc_r) * 31'(YEAR_DIV));
    s5_c_nxt = s4_qc_r + 15'(s5_rc >= 30'(YEAR_DIV));
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_b_r <= s4_b_r;
      s5_c_r <= s5_c_nxt;
    end
  end

  // Stage 6: day count within the year that starts in March.
  logic [14:0] s6_c_r;
  logic [8:0]  s6_rem_r, s6_rem_nxt;
  logic [23:0] s6_d;

  always_comb begin
    s6_d       = 24'(s5_c_r) * 24'd365 + 24'(s5_c_r[14:2]);
    s6_rem_nxt = 9'(s5_b_r - s6_d);
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_c_r   <= s5_c_r;
      s6_rem_r <= s6_rem_nxt;
    end
  end

  // Stage 7: month index estimate.
  logic [14:0] s7_c_r;
  logic [8:0]  s7_rem_r;
  logic [22:0] s7_xe_r, s7_xe_nxt;
  logic [3:0]  s7_qe_r, s7_qe_nxt;
  logic [20:0] s7_pe;

  always_comb begin
    s7_xe_nxt = 23'(s6_rem_r) * 23'(MONTH_DEN);
    s7_pe     = 21'(s6_rem_r) * 21'(MONTH_RECIP);
    s7_qe_nxt = s7_pe[MONTH_SHIFT +: 4];
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_c_r   <= s6_c_r;
      s7_rem_r <= s6_rem_r;
      s7_xe_r  <= s7_xe_nxt;
      s7_qe_r  <= s7_qe_nxt;
    end
  end

  // Stage 8: month index correction.
  logic [14:0] s8_c_r;
  logic [8:0]  s8_rem_r;
  logic [3:0]  s8_e_r, s8_e_nxt;
  logic [22:0] s8_re;

  always_comb begin
    s8_re    = s7_xe_r - 23'(23'(s7_qe_r) * 23'(MONTH_NUM));
    s8_e_nxt = s7_qe_r + 4'(s8_re >= 23'(MONTH_NUM));
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_c_r   <= s7_c_r;
      s8_rem_r <= s7_rem_r;
      s8_e_r   <= s8_e_nxt;
    end
  end

  // Stage 9: output register with day, month and year.
  logic [MONTH_W-1:0]       month_r, month_nxt;
  logic [DOM_W-1:0]         dom_r,   dom_nxt;
  logic signed [YEAR_W-1:0] year_r,  year_nxt;
  logic [3:0]               mon_m1;
  logic signed [16:0]       yr;

  always_comb begin
    dom_nxt = 5'(s8_rem_r - days_before(s8_e_r));
    mon_m1  = s8_e_r - 4'd1;
    if (mon_m1 > 4'd12) begin
      month_nxt = mon_m1 - 4'd12;
    end else begin
      month_nxt = mon_m1;
    end
    // January and February belong to the following year count.
    yr = $signed({2'b00, s8_c_r}) - YEAR_BASE;
    if (month_nxt > 4'd2) begin
      yr = yr - 17'sd1;
    end
    if (yr <= 17'sd0) begin
      yr = yr - 17'sd1;
    end
    year_nxt = YEAR_W'(yr);
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      month_r <= month_nxt;
      dom_r   <= dom_nxt;
      year_r  <= year_nxt;
    end
  end

  assign out_chan.month        = month_r;
  assign out_chan.day_of_month = dom_r;
  assign out_chan.year         = year_r;

endmodule

`default_nettype wire

### hw/rtl/jdc_checker.sv
`default_nettype none

module jdc_checker import jdc_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [MONTH_W-1:0]       month,
  input wire logic [DOM_W-1:0]         day_of_month,
  input wire logic signed [YEAR_W-1:0] year
);

  // Reset leaves the pipeline empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // With no result waiting, every stage can move, so the input is ready.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while output is empty");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(month) && $stable(day_of_month)
      && $stable(year))
    else $error("stalled result changed");

  // Every shown date has a month from 1 to 12, a day of month of at least 1 and no year zero.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
      && year != 16'sd0)
    else $error("result out of range");

endmodule

bind julian_day_to_calendar_date_core jdc_checker u_jdc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .month        (out_chan.month),
  .day_of_month (out_chan.day_of_month),
  .year         (out_chan.year)
);

`default_nettype wire
